// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only outside reset
`define ASSERT_CLKD(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// property that also holds across reset
`define ASSERT_CLKA(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: rtl/gdc_pkg.sv
// ----------------------------------------------------------------------------
// gdc_pkg
// types and codes shared by the gate and door controller
// ----------------------------------------------------------------------------
package gdc_pkg;

   // leaf positions
   localparam logic [1:0] POS_CLOSED  = 2'd0;
   localparam logic [1:0] POS_OPENING = 2'd1;
   localparam logic [1:0] POS_OPENED  = 2'd2;
   localparam logic [1:0] POS_CLOSING = 2'd3;

   // relay sequencer phases
   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_GATE_ON  = 3'd1;
   localparam logic [2:0] PH_GATE_OFF = 3'd2;
   localparam logic [2:0] PH_DOOR_ON  = 3'd3;
   localparam logic [2:0] PH_DOOR_OFF = 3'd4;

   // item kinds
   localparam logic [1:0] KIND_GATE_CMD  = 2'd0;
   localparam logic [1:0] KIND_DOOR_CMD  = 2'd1;
   localparam logic [1:0] KIND_RELAY_TCK = 2'd2;
   localparam logic [1:0] KIND_MOTOR_TCK = 2'd3;

   // command codes
   localparam logic [1:0] CMD_OPEN  = 2'd0;
   localparam logic [1:0] CMD_CLOSE = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;

   localparam logic [3:0] VOTE_THRESHOLD_RESET = 4'd5;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] command;
      logic [3:0] open_pin_high_count;
      logic [3:0] close_pin_high_count;
      logic       gate_open_sensed;
   } item_type;

   typedef struct packed {
      logic [1:0] gate_state;
      logic [1:0] door_leaf;
      logic [2:0] relay_phase;
      logic       gate_relay_level;
      logic       door_relay_level;
      logic       motor_was_opening;
      logic       motor_was_closing;
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0] gate_position;
      logic [1:0] door_position;
      logic       gate_relay_on;
      logic       door_relay_on;
      logic       command_accepted;
   } result_type;

endpackage

// File: rtl/gdc_step.sv
// ----------------------------------------------------------------------------
// gdc_step
// next-state and result logic for one item of the gate and door controller
// ----------------------------------------------------------------------------
module gdc_step (
   input  gdc_pkg::item_type       item,
   input  gdc_pkg::ctrl_state_type cur,
   input  logic [3:0]              vote_threshold,
   output gdc_pkg::ctrl_state_type nxt,
   output gdc_pkg::result_type     result
);

   function automatic logic cmd_suits(input logic [1:0] pos, input logic [1:0] cmd);
      logic ok;
      case (cmd)
         gdc_pkg::CMD_OPEN:  ok = (pos == gdc_pkg::POS_CLOSED);
         gdc_pkg::CMD_CLOSE: ok = (pos == gdc_pkg::POS_OPENED);
         gdc_pkg::CMD_STOP:  ok = (pos == gdc_pkg::POS_OPENING) ||
                                  (pos == gdc_pkg::POS_CLOSING);
         default:            ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic logic [1:0] cmd_target(input logic [1:0] cmd);
      logic [1:0] pos;
      case (cmd)
         gdc_pkg::CMD_OPEN:  pos = gdc_pkg::POS_OPENING;
         gdc_pkg::CMD_CLOSE: pos = gdc_pkg::POS_CLOSING;
         default:            pos = gdc_pkg::POS_OPENED;
      endcase
      return pos;
   endfunction

   logic motor_opening;
   logic motor_closing;
   logic accepted;

   // sense pins are active low: a pin not reading high means that motor runs
   assign motor_opening = !(item.open_pin_high_count > vote_threshold);
   assign motor_closing = !(item.close_pin_high_count > vote_threshold);

   always_comb begin
      nxt      = cur;
      accepted = 1'b0;
      case (item.kind)
         gdc_pkg::KIND_GATE_CMD: begin
            if (cur.relay_phase == gdc_pkg::PH_IDLE &&
                cur.door_leaf == gdc_pkg::POS_CLOSED &&
                cmd_suits(cur.gate_state, item.command)) begin
               nxt.relay_phase = gdc_pkg::PH_GATE_ON;
               nxt.gate_state  = cmd_target(item.command);
               accepted        = 1'b1;
            end
         end
         gdc_pkg::KIND_DOOR_CMD: begin
            if (cur.relay_phase == gdc_pkg::PH_IDLE &&
                cur.gate_state == gdc_pkg::POS_CLOSED &&
                cmd_suits(cur.door_leaf, item.command)) begin
               nxt.relay_phase = gdc_pkg::PH_DOOR_ON;
               nxt.door_leaf   = cmd_target(item.command);
               accepted        = 1'b1;
            end
         end
         gdc_pkg::KIND_RELAY_TCK: begin
            case (cur.relay_phase)
               gdc_pkg::PH_IDLE: ;
               gdc_pkg::PH_GATE_ON: begin
                  nxt.gate_relay_level = 1'b1;
                  nxt.relay_phase      = gdc_pkg::PH_GATE_OFF;
               end
               gdc_pkg::PH_GATE_OFF: begin
                  nxt.gate_relay_level = 1'b0;
                  nxt.relay_phase      = gdc_pkg::PH_IDLE;
               end
               gdc_pkg::PH_DOOR_ON: begin
                  nxt.door_relay_level = 1'b1;
                  nxt.relay_phase      = gdc_pkg::PH_DOOR_OFF;
               end
               gdc_pkg::PH_DOOR_OFF: begin
                  nxt.door_relay_level = 1'b0;
                  nxt.relay_phase      = gdc_pkg::PH_IDLE;
               end
               default: nxt.relay_phase = gdc_pkg::PH_IDLE;
            endcase
         end
         default: begin
            // opening vote first, the closing vote sees its result
            if (motor_opening) begin
               if (cur.gate_state == gdc_pkg::POS_CLOSED &&
                   cur.door_leaf == gdc_pkg::POS_CLOSED)
                  nxt.gate_state = gdc_pkg::POS_OPENING;
               nxt.motor_was_opening = 1'b1;
            end else if (cur.motor_was_opening && item.gate_open_sensed) begin
               if (cur.gate_state == gdc_pkg::POS_OPENING)
                  nxt.gate_state = gdc_pkg::POS_OPENED;
               else if (cur.door_leaf == gdc_pkg::POS_OPENING)
                  nxt.door_leaf = gdc_pkg::POS_OPENED;
               nxt.motor_was_opening = 1'b0;
            end

            if (motor_closing) begin
               if (nxt.gate_state == gdc_pkg::POS_OPENED)
                  nxt.gate_state = gdc_pkg::POS_CLOSING;
               else if (nxt.door_leaf == gdc_pkg::POS_OPENED)
                  nxt.door_leaf = gdc_pkg::POS_CLOSING;
               nxt.motor_was_closing = 1'b1;
            end else if (cur.motor_was_closing && !item.gate_open_sensed) begin
               nxt.gate_state        = gdc_pkg::POS_CLOSED;
               nxt.door_leaf         = gdc_pkg::POS_CLOSED;
               nxt.motor_was_closing = 1'b0;
            end
         end
      endcase
   end

   assign result.gate_position    = nxt.gate_state;
   assign result.door_position    = nxt.door_leaf;
   assign result.gate_relay_on    = nxt.gate_relay_level;
   assign result.door_relay_on    = nxt.door_relay_level;
   assign result.command_accepted = accepted;

endmodule

// File: rtl/gate_and_door_controller.sv
// ----------------------------------------------------------------------------
// gate_and_door_controller
// gate and pedestrian door position tracker with relay pulse sequencing
// ----------------------------------------------------------------------------
// req_* carries one item per handshake: kind in req_tuser (gate command,
// door command, relay tick, motor tick), command code, the two ten-sample
// sense pin counts and the open sensor in req_tdata.
// rsp_* returns exactly one item per request: both leaf positions, both
// relay levels and whether a command was taken.
// csr_* writes the vote threshold; write it only while no item is in flight.
// the request handshake loads the input register; the step result moves on
// into the result register, which drives rsp_tvalid, once that is free.
// throughput: one item per cycle unless rsp_tready stalls the response; the
// state update is a single pass of the step logic, so an item may follow the
// previous one right away.
// reset clears the positions, relay sequencer, motor flags and both
// pipeline valid bits and loads the threshold with 5.
// a stalled receiver holds the response; the input register still takes
// one more item, after which req_tready drops until the response is taken.
// ----------------------------------------------------------------------------
module gate_and_door_controller (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [1:0] command, [5:2] open_pin_high_count, [9:6] close_pin_high_count,
   // [10] gate_open_sensed, [15:11] zero
   input  logic [gdc_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] kind
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [1:0] gate_position, [3:2] door_position, [4] gate_relay_on,
   // [5] door_relay_on, [6] command_accepted, [7] zero
   output logic [gdc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [3:0]                     csr_data
);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   gdc_pkg::item_type       in_item_ff;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   gdc_pkg::result_type     out_result_ff;
   gdc_pkg::ctrl_state_type state_ff;
   gdc_pkg::ctrl_state_type state_in;
   gdc_pkg::result_type     step_result;
   logic [3:0]              threshold_ff;
   logic                    out_free;
   logic                    advance;
   logic                    req_take;

   assign out_free = !out_valid_ff || rsp_tready;
   assign advance  = in_valid_ff && out_free;
   assign req_take = req_tvalid && req_tready;

   assign req_tready = !in_valid_ff || out_free;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   gdc_step u_step (
      .item           (in_item_ff),
      .cur            (state_ff),
      .vote_threshold (threshold_ff),
      .nxt            (state_in),
      .result         (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         threshold_ff <= gdc_pkg::VOTE_THRESHOLD_RESET;
         state_ff     <= '{gate_state:        gdc_pkg::POS_CLOSED,
                           door_leaf:         gdc_pkg::POS_CLOSED,
                           relay_phase:       gdc_pkg::PH_IDLE,
                           gate_relay_level:  1'b0,
                           door_relay_level:  1'b0,
                           motor_was_opening: 1'b0,
                           motor_was_closing: 1'b0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            threshold_ff <= csr_data;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.kind                 <= req_tuser;
         in_item_ff.command              <= req_tdata[1:0];
         in_item_ff.open_pin_high_count  <= req_tdata[5:2];
         in_item_ff.close_pin_high_count <= req_tdata[9:6];
         in_item_ff.gate_open_sensed     <= req_tdata[10];
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0,
                        out_result_ff.command_accepted,
                        out_result_ff.door_relay_on,
                        out_result_ff.gate_relay_on,
                        out_result_ff.door_position,
                        out_result_ff.gate_position};

endmodule

// File: rtl/gdc_checker.sv
// ----------------------------------------------------------------------------
// gdc_checker
// port-level checks for the gate and door controller
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [gdc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic [1:0] gate_pos;
   logic [1:0] door_pos;
   logic       gate_relay;
   logic       door_relay;
   logic       accepted;

   assign gate_pos   = rsp_tdata[1:0];
   assign door_pos   = rsp_tdata[3:2];
   assign gate_relay = rsp_tdata[4];
   assign door_relay = rsp_tdata[5];
   assign accepted   = rsp_tdata[6];

   // no response survives reset
   `ASSERT_CLKA(a_reset_clears_rsp, clock, reset |=> !rsp_tvalid)

   // a stalled response holds
   `ASSERT_CLKD(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // only one leaf can be away from closed
   `ASSERT_CLKD(a_one_leaf_moves, clock, reset,
      rsp_tvalid |-> gate_pos == gdc_pkg::POS_CLOSED || door_pos == gdc_pkg::POS_CLOSED)

   // relays pulse one at a time
   `ASSERT_CLKD(a_relays_exclusive, clock, reset, rsp_tvalid |-> !(gate_relay && door_relay))

   // commands are taken only with the sequencer idle, so both relays are off
   `ASSERT_CLKD(a_accept_relays_off, clock, reset,
      rsp_tvalid && accepted |-> !gate_relay && !door_relay)

endmodule

bind gate_and_door_controller gdc_checker u_gdc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
